/* hdl/mwe_pkg.sv */
`default_nettype none
package mwe_pkg;
    typedef struct packed {
        logic [63:0] tick_time;
        logic        chip_select;
        logic        data_in;
    } t_in_item;

    typedef struct packed {
        logic out_driven;
        logic out_bit;
        logic busy_res;
    } t_out_item;

    localparam logic [0:0] REG_DEVICE_TYPE = 1'd0;
    localparam logic [0:0] REG_WORD_MODE16 = 1'd1;
endpackage
`default_nettype wire

/* hdl/mwe_front.sv */
`default_nettype none
// two-entry input queue; stalls the source when both entries are full
module mwe_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire mwe_pkg::t_in_item i_item,
    input  wire                logic i_valid,
    output logic                     o_stall,
    output mwe_pkg::t_in_item        o_item,
    output logic                     o_valid,
    input  wire                logic i_take
);
    mwe_pkg::t_in_item r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push;
    logic       w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = i_take && o_valid;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) begin
                if (w_pop) r_q[~r_rd] <= i_item;
                else       r_q[r_rd ^ r_cnt[0]] <= i_item;
            end
            if (w_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/microwire_serial_eeprom_core.sv */
`default_nettype none
// 93Cxx microwire eeprom model. one item is one serial clock tick and yields one
// result item. a plain tick passes through the queue, the execute step and the
// output register, and the next item is taken only once the result has left. the
// last opcode or data bit of a command adds a decode step (S_RD0); a read start
// adds memory reads in S_RD0 and S_RD1 (low byte, then high byte for 16-bit words).
// when writes are enabled, eral and wral sweep the store one byte a cycle (up to
// MEM_BYTES bytes) before the result is given. after reset a clearing pass fills
// all MEM_BYTES bytes of the store with 0xff; no item is taken until it ends.
module microwire_serial_eeprom_core #(
    parameter int MEM_BYTES  = 2048,
    parameter longint unsigned WRITE_TIME = 4096,
    parameter longint unsigned ERAL_TIME  = 4096,
    parameter longint unsigned WRAL_TIME  = 4096
) (
    input  wire                 logic i_clk,
    input  wire                 logic i_rst_n,
    input  wire mwe_pkg::t_in_item  i_item,
    input  wire                 logic i_valid,
    output logic                      o_stall,
    output mwe_pkg::t_out_item        o_item,
    output logic                      o_valid,
    input  wire                 logic i_stall,
    input  wire                 logic i_cfg_we,
    input  wire           logic [0:0] i_cfg_index,
    input  wire           logic [2:0] i_cfg_data
);
    localparam int AW = $clog2(MEM_BYTES);

    // phases
    typedef enum logic [2:0] {PH_IDLE, PH_CMD, PH_WDATA, PH_WRAL, PH_READ, PH_DONE}
        t_phase;
    typedef enum logic [2:0] {S_CLEAR, S_RUN, S_RD0, S_RD1, S_SWEEP, S_OUT} t_state;
    typedef enum logic [1:0] {OUT_NONE = 2'd0, OUT_LOW = 2'd2, OUT_HIGH = 2'd3} t_outst;

    mwe_pkg::t_in_item w_it;
    logic w_qv, w_take;

    mwe_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_valid(i_valid),
        .o_stall(o_stall), .o_item(w_it), .o_valid(w_qv), .i_take(w_take)
    );

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_rdata;
    logic [2:0]  r_dev;
    logic        r_w16;
    t_state      r_st;
    t_phase      r_ph;
    t_outst      r_os;
    logic        r_we, r_sel;
    logic [63:0] r_busy;
    logic [4:0]  r_bc;
    logic [12:0] r_op;
    logic [15:0] r_ds;
    logic [AW:0] r_ptr;
    logic [AW:0] r_lim;
    logic [15:0] r_sw;
    logic [63:0] r_now;

    // config-derived geometry
    logic [2:0]  w_di;
    logic [3:0]  w_ob;
    logic [10:0] w_am;
    logic [11:0] w_sz;
    logic [4:0]  w_db;
    logic [10:0] w_addr;
    logic [11:0] w_ba;
    logic        w_inr;
    logic        w_idle_ok;
    logic        w_exec;

    always_comb begin
        w_di = (r_dev >= 3'd1 && r_dev <= 3'd5) ? r_dev : 3'd1;
        unique case (w_di)
            3'd2:    begin w_ob = 4'd11; w_am = 11'h0FF; w_sz = 12'd256;  end
            3'd3:    begin w_ob = 4'd11; w_am = 11'h1FF; w_sz = 12'd512;  end
            3'd4:    begin w_ob = 4'd13; w_am = 11'h3FF; w_sz = 12'd1024; end
            3'd5:    begin w_ob = 4'd13; w_am = 11'h7FF; w_sz = 12'd2048; end
            default: begin w_ob = 4'd9;  w_am = 11'h07F; w_sz = 12'd128;  end
        endcase
        if (r_w16) begin
            w_ob = w_ob - 4'd1;
            w_am = w_am >> 1;
        end
        if (w_sz > 12'(MEM_BYTES)) w_sz = 12'(MEM_BYTES);
        w_db   = r_w16 ? 5'd16 : 5'd8;
        w_addr = r_op[10:0] & w_am;
        w_ba   = r_w16 ? {w_addr, 1'b0} : {1'b0, w_addr};
        w_inr  = r_w16 ? ((w_ba + 12'd1) < w_sz) : (w_ba < w_sz);
    end

    // output item is only held while waiting for the sink
    assign w_take   = (r_st == S_RUN) && w_qv && !o_valid;
    assign w_idle_ok = 1'b1;

    // taken tick ends a shift phase or starts a read: go through the execute step
    assign w_exec = r_sel && w_it.chip_select && (r_busy < w_it.tick_time) &&
                    (((r_ph == PH_CMD) && ({1'b0, r_bc + 5'd1} >= {2'b0, w_ob})) ||
                     ((r_ph == PH_WDATA || r_ph == PH_WRAL) && (r_bc + 5'd1 >= w_db)) ||
                     ((r_ph == PH_READ) && (r_bc == 5'd0)));

    function automatic logic [63:0] f_sat(input logic [63:0] a, input logic [63:0] d);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, d};
        return s[64] ? '1 : s[63:0];
    endfunction

    logic       w_bsy;
    assign w_bsy = !(r_busy < r_now);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= 3'd1; r_w16 <= 1'b0;
            r_st <= S_CLEAR; r_ph <= PH_IDLE; r_os <= OUT_NONE;
            r_we <= 1'b0; r_sel <= 1'b0; r_busy <= '0; r_bc <= '0;
            r_op <= '0; r_ds <= '0; r_ptr <= '0; o_valid <= 1'b0;
        end else begin
            if (i_cfg_we && w_idle_ok) begin
                if (i_cfg_index == mwe_pkg::REG_DEVICE_TYPE) r_dev <= i_cfg_data;
                else r_w16 <= i_cfg_data[0];
            end
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_st)
                S_CLEAR: begin
                    r_mem[r_ptr[AW-1:0]] <= 8'hFF;
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == (AW+1)'(MEM_BYTES - 1)) r_st <= S_RUN;
                end
                S_RUN: if (w_take) begin
                    r_now <= w_it.tick_time;
                    // decode runs in S_RD0 with shifted opcode
                    r_st  <= w_exec ? S_RD0 : S_OUT;
                    if (r_sel) begin
                        if (!w_it.chip_select) begin
                            r_ph <= PH_IDLE; r_bc <= '0; r_sel <= 1'b0;
                        end else if (r_busy < w_it.tick_time) begin
                            unique case (r_ph)
                                PH_CMD: begin
                                    r_op <= {r_op[11:0], w_it.data_in};
                                    r_bc <= r_bc + 5'd1;
                                end
                                PH_WDATA, PH_WRAL: begin
                                    r_ds <= {r_ds[14:0], w_it.data_in};
                                    r_bc <= r_bc + 5'd1;
                                end
                                PH_READ: begin
                                    if (r_bc >= w_db) begin
                                        r_os <= OUT_NONE; r_ph <= PH_DONE;
                                    end else if (r_bc != 5'd0) begin
                                        r_os <= r_ds[4'(w_db - 5'd1 - r_bc)] ?
                                                OUT_HIGH : OUT_LOW;
                                        r_bc <= r_bc + 5'd1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end else if (w_it.chip_select && w_it.data_in) begin
                        if (r_busy < w_it.tick_time) begin
                            r_ph <= PH_CMD; r_bc <= '0; r_op <= '0; r_ds <= '0;
                            r_os <= OUT_NONE;
                        end
                        r_sel <= 1'b1;
                    end
                end
                S_RD0: begin
                    // execution step after the last shifted bit
                    unique case (r_ph)
                        PH_CMD: begin
                            r_bc <= '0; r_ds <= '0;
                            // only an enabled eral sweeps the store
                            r_st <= ((r_op[4'(w_ob - 4'd1) -: 2] == 2'd0) &&
                                     (r_op[4'(w_ob - 4'd3) -: 2] == 2'd2) && r_we) ?
                                    S_SWEEP : S_OUT;
                            unique case (r_op[4'(w_ob - 4'd1) -: 2])
                                2'd0: begin
                                    unique case (r_op[4'(w_ob - 4'd3) -: 2])
                                        2'd1: r_ph <= PH_WRAL;
                                        2'd0: begin r_we <= 1'b0; r_os <= OUT_NONE;
                                                    r_ph <= PH_DONE; end
                                        2'd3: begin r_we <= 1'b1; r_os <= OUT_NONE;
                                                    r_ph <= PH_DONE; end
                                        default: begin
                                            r_os <= OUT_NONE; r_ph <= PH_DONE;
                                            if (r_we) begin
                                                r_sw <= 16'hFFFF; r_ptr <= '0;
                                                r_lim <= (AW+1)'(w_sz);
                                                r_busy <= f_sat(r_now, ERAL_TIME);
                                            end
                                        end
                                    endcase
                                end
                                2'd1: r_ph <= PH_WDATA;
                                2'd2: begin r_os <= OUT_LOW; r_ph <= PH_READ; end
                                default: begin
                                    r_os <= OUT_HIGH; r_ph <= PH_DONE;
                                    if (r_we) begin
                                        if (w_inr) begin
                                            r_mem[w_ba[AW-1:0]] <= 8'hFF;
                                            if (r_w16)
                                                r_mem[AW'(w_ba + 12'd1)] <= 8'hFF;
                                        end
                                        r_busy <= f_sat(r_now, WRITE_TIME);
                                    end
                                end
                            endcase
                        end
                        PH_WDATA: begin
                            r_st <= S_OUT;
                            r_os <= OUT_HIGH; r_ph <= PH_DONE;
                            if (r_we) begin
                                if (w_inr) begin
                                    r_mem[w_ba[AW-1:0]] <= r_ds[7:0];
                                    if (r_w16) r_mem[AW'(w_ba + 12'd1)] <= r_ds[15:8];
                                end
                                r_busy <= f_sat(r_now, WRITE_TIME);
                            end
                        end
                        PH_WRAL: begin
                            r_st <= r_we ? S_SWEEP : S_OUT;
                            r_os <= OUT_HIGH; r_ph <= PH_DONE;
                            if (r_we) begin
                                r_sw <= r_w16 ? r_ds : {r_ds[7:0], r_ds[7:0]};
                                r_ptr <= '0; r_lim <= (AW+1)'(w_sz);
                                r_busy <= f_sat(r_now, WRAL_TIME);
                            end
                        end
                        default: begin
                            // read start: fetch low byte
                            r_rdata <= r_mem[w_ba[AW-1:0]];
                            r_ptr <= '0;
                            r_st <= S_RD1;
                        end
                    endcase
                end
                S_RD1: begin
                    if (r_ptr == '0) begin
                        r_ds[7:0] <= w_inr ? r_rdata : 8'hFF;
                        r_rdata <= r_mem[AW'(w_ba + 12'd1)];
                        r_ptr <= r_w16 ? (AW+1)'(1) : (AW+1)'(2);
                        if (!r_w16) r_ds[15:8] <= 8'h00;
                    end else if (r_ptr == (AW+1)'(1)) begin
                        r_ds[15:8] <= w_inr ? r_rdata : 8'hFF;
                        r_ptr <= (AW+1)'(2);
                    end else begin
                        r_os <= r_ds[4'(w_db - 5'd1)] ? OUT_HIGH : OUT_LOW;
                        r_bc <= 5'd1;
                        r_st <= S_OUT;
                    end
                end
                S_SWEEP: begin
                    r_mem[r_ptr[AW-1:0]] <= r_ptr[0] ? r_sw[15:8] : r_sw[7:0];
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr + 1'b1 >= r_lim) r_st <= S_OUT;
                end
                default: begin
                    o_valid <= 1'b1;
                    o_item.busy_res   <= w_bsy;
                    o_item.out_driven <= w_bsy ? 1'b1 : r_os[1];
                    o_item.out_bit    <= w_bsy ? 1'b0 : (r_os == OUT_HIGH);
                    r_st <= S_RUN;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
